// ===== hw/rtl/bstk_pkg.sv =====
// Shared constants and types for the bounded sorted top-k insertion buffer.
`timescale 1ns / 1ps

package bstk_pkg;

    localparam int SLOTS   = 8;
    localparam int OUT_MAX = 8;
    localparam int KEY_W   = 20;
    localparam int TAG_W   = 16;
    localparam int IDX_W   = 3;
    localparam int CNT_W   = $clog2(SLOTS + 1);

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_READ   = 2'd1;
    localparam logic [1:0] ACT_CLEAR  = 2'd2;

    typedef struct packed {
        logic ins;
        logic rot;
    } cell_cmd_t;

endpackage

// ===== hw/rtl/bstk_cell.sv =====
// One compare-and-shift storage cell of the sorted chain.
`timescale 1ns / 1ps

module bstk_cell
(
    input  logic                     clk,
    input  bstk_pkg::cell_cmd_t      cmd,
    input  logic                     valid,
    input  logic [bstk_pkg::KEY_W-1:0] new_key,
    input  logic [bstk_pkg::TAG_W-1:0] new_tag,
    input  logic                     prev_keep,
    input  logic [bstk_pkg::KEY_W-1:0] prev_key,
    input  logic [bstk_pkg::TAG_W-1:0] prev_tag,
    input  logic [bstk_pkg::KEY_W-1:0] next_key,
    input  logic [bstk_pkg::TAG_W-1:0] next_tag,
    output logic                     keep,
    output logic [bstk_pkg::KEY_W-1:0] key,
    output logic [bstk_pkg::TAG_W-1:0] tag
);

    logic [bstk_pkg::KEY_W-1:0] key_reg;
    logic [bstk_pkg::KEY_W-1:0] key_next;
    logic [bstk_pkg::TAG_W-1:0] tag_reg;
    logic [bstk_pkg::TAG_W-1:0] tag_next;

    // A held entry whose key does not exceed the new one stays in place.
    assign keep = valid && (key_reg <= new_key);
    assign key  = key_reg;
    assign tag  = tag_reg;

    always_comb
    begin
        key_next = key_reg;
        tag_next = tag_reg;
        if (cmd.rot)
        begin
            key_next = next_key;
            tag_next = next_tag;
        end
        else if (cmd.ins && !keep)
        begin
            if (prev_keep)
            begin
                key_next = new_key;
                tag_next = new_tag;
            end
            else
            begin
                key_next = prev_key;
                tag_next = prev_tag;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        tag_reg <= tag_next;
    end

endmodule

// ===== hw/rtl/bounded_sorted_top_k_insert.sv =====
// Top level of the bounded sorted top-k insertion buffer with its readout control.
// An insert or a clear leaves busy low, so one item per cycle is taken while not busy.
// A readout of a non-empty buffer rotates the cell chain once around while busy,
// emitting one result per cycle for each held entry, from the head cell after busy is set.
// An empty readout emits its single result in the cycle after the item and is not busy.
// Reset clears the entry count and the readout control; results cannot be stalled.
`timescale 1ns / 1ps

module bounded_sorted_top_k_insert
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   action,
    input  logic [bstk_pkg::KEY_W-1:0]   key,
    input  logic [bstk_pkg::TAG_W-1:0]   payload_tag,
    output logic                         res_valid,
    output logic [bstk_pkg::KEY_W-1:0]   key_res,
    output logic [bstk_pkg::TAG_W-1:0]   payload_tag_res,
    output logic [bstk_pkg::IDX_W-1:0]   slot_index,
    output logic                         last,
    output logic                         empty_res
);

    localparam int SLOTS = bstk_pkg::SLOTS;
    localparam int CNT_W = bstk_pkg::CNT_W;

    logic                       accept;
    logic [CNT_W-1:0]           held_count_reg;
    logic                       rd_active_reg;
    logic [CNT_W-1:0]           rd_cnt_reg;
    logic                       res_valid_reg;
    logic [CNT_W-1:0]           n_lim;
    bstk_pkg::cell_cmd_t        cmd;

    logic [bstk_pkg::KEY_W-1:0] key_res_reg;
    logic [bstk_pkg::TAG_W-1:0] tag_res_reg;
    logic [bstk_pkg::IDX_W-1:0] slot_index_reg;
    logic                       last_reg;
    logic                       empty_reg;

    logic [SLOTS-1:0]           cell_valid;
    logic [SLOTS-1:0]           cell_keep;
    logic [bstk_pkg::KEY_W-1:0] cell_key [SLOTS];
    logic [bstk_pkg::TAG_W-1:0] cell_tag [SLOTS];

    assign accept  = start && !busy;
    assign busy    = rd_active_reg;
    assign cmd.ins = accept && (action == bstk_pkg::ACT_INSERT);
    assign cmd.rot = rd_active_reg;

    always_comb
    begin
        if (32'(held_count_reg) > bstk_pkg::OUT_MAX)
            n_lim = CNT_W'(bstk_pkg::OUT_MAX);
        else
            n_lim = held_count_reg;
    end

    for (genvar i = 0; i < SLOTS; i++)
    begin : g_cell
        localparam int PREV = (i == 0) ? 0 : i - 1;
        localparam int NEXT = (i == SLOTS - 1) ? 0 : i + 1;

        assign cell_valid[i] = (CNT_W'(i) < held_count_reg);

        bstk_cell u_cell
        (
            .clk       (clk),
            .cmd       (cmd),
            .valid     (cell_valid[i]),
            .new_key   (key),
            .new_tag   (payload_tag),
            .prev_keep ((i == 0) ? 1'b1 : cell_keep[PREV]),
            .prev_key  (cell_key[PREV]),
            .prev_tag  (cell_tag[PREV]),
            .next_key  (cell_key[NEXT]),
            .next_tag  (cell_tag[NEXT]),
            .keep      (cell_keep[i]),
            .key       (cell_key[i]),
            .tag       (cell_tag[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_count_reg <= '0;
            rd_active_reg  <= 1'b0;
            rd_cnt_reg     <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            res_valid_reg <= 1'b0;
            if (rd_active_reg)
            begin
                res_valid_reg <= (rd_cnt_reg < n_lim);
                rd_cnt_reg    <= CNT_W'(rd_cnt_reg + 1'b1);
                if (rd_cnt_reg == CNT_W'(SLOTS - 1))
                    rd_active_reg <= 1'b0;
            end
            else if (accept)
            begin
                case (action)
                    bstk_pkg::ACT_INSERT:
                    begin
                        if (held_count_reg < CNT_W'(SLOTS))
                            held_count_reg <= CNT_W'(held_count_reg + 1'b1);
                    end
                    bstk_pkg::ACT_READ:
                    begin
                        if (held_count_reg == '0)
                            res_valid_reg <= 1'b1;
                        else
                        begin
                            rd_active_reg <= 1'b1;
                            rd_cnt_reg    <= '0;
                        end
                    end
                    bstk_pkg::ACT_CLEAR:
                    begin
                        held_count_reg <= '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_active_reg)
        begin
            key_res_reg    <= cell_key[0];
            tag_res_reg    <= cell_tag[0];
            slot_index_reg <= bstk_pkg::IDX_W'(rd_cnt_reg);
            last_reg       <= (CNT_W'(rd_cnt_reg + 1'b1) == n_lim);
            empty_reg      <= 1'b0;
        end
        else if (accept && (action == bstk_pkg::ACT_READ) && (held_count_reg == '0))
        begin
            key_res_reg    <= '0;
            tag_res_reg    <= '0;
            slot_index_reg <= '0;
            last_reg       <= 1'b1;
            empty_reg      <= 1'b1;
        end
    end

    assign res_valid       = res_valid_reg;
    assign key_res         = key_res_reg;
    assign payload_tag_res = tag_res_reg;
    assign slot_index      = slot_index_reg;
    assign last            = last_reg;
    assign empty_res       = empty_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_count_reg <= CNT_W'(SLOTS))
        else $error("entry count exceeds the number of slots");

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && empty_res |-> last && (key_res == '0) && (payload_tag_res == '0))
        else $error("empty result is not a lone zeroed final item");

    a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (action == bstk_pkg::ACT_READ) && (held_count_reg != '0) |=> busy)
        else $error("readout of a non-empty buffer did not go busy");

    a_full_turn: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> ($past(rd_cnt_reg) == CNT_W'(SLOTS - 1)))
        else $error("readout ended before a full rotation of the chain");

    a_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> $stable(held_count_reg))
        else $error("entry count changed during a readout");
`endif

endmodule
